### rtl/core/stf_pkg.sv
// Shared types and constants for the session table replay filter.
// Holds the probe record that walks the cell chain and the table write command.
// No dependencies.
package stf_pkg;

    localparam int SESSIONS_DEF = 8;
    // Index fields are sized for the largest supported table (64 entries).
    localparam int IDX_W = 6;

    localparam logic [1:0] OP_OPEN   = 2'd0;
    localparam logic [1:0] OP_RESUME = 2'd1;

    localparam logic [2:0] ST_OPENED   = 3'd0;
    localparam logic [2:0] ST_RESUMED  = 3'd1;
    localparam logic [2:0] ST_UNKNOWN  = 3'd2;
    localparam logic [2:0] ST_ACCEPTED = 3'd3;
    localparam logic [2:0] ST_REPLAY   = 3'd4;

    typedef struct packed {
        logic             valid;
        logic [1:0]       op;
        logic [63:0]      sid;
        logic [63:0]      nsid;
        logic [31:0]      addr;
        logic [15:0]      port;
        logic [31:0]      seq;
        logic [31:0]      now;
        logic             hit;
        logic [IDX_W-1:0] hit_idx;
        logic [31:0]      hit_seq;
        logic             free;
        logic [IDX_W-1:0] free_idx;
        logic [31:0]      min_t;
        logic [IDX_W-1:0] min_idx;
    } t_probe;

    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] idx;
        logic             open;
        logic             set_addr;
        logic             set_seq;
        logic [63:0]      id;
        logic [31:0]      addr;
        logic [15:0]      port;
        logic [31:0]      seq;
        logic [31:0]      now;
    } t_wr_cmd;

endpackage

### rtl/core/stf_cell.sv
// One entry of the session table plus one stage of the probe chain.
// Depends on stf_pkg for the probe record and the write command.
module stf_cell #(
    parameter int IDX = 0
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  stf_pkg::t_probe  i_probe,
    input  stf_pkg::t_wr_cmd i_wr,
    output stf_pkg::t_probe  o_probe
);
    import stf_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

    logic        r_valid;
    logic [63:0] r_id;
    logic [31:0] r_addr;
    logic [15:0] r_port;
    logic [31:0] r_last_seq;
    logic [31:0] r_last_seen;

    t_probe r_probe;
    t_probe n_probe;
    logic   w_sel;

    assign w_sel = i_wr.valid && (i_wr.idx == MY_IDX);

    // Lowest matching entry wins, so a probe that already hit passes through.
    always_comb begin
        n_probe = i_probe;
        if (r_valid && (r_id == i_probe.sid) && !i_probe.hit) begin
            n_probe.hit     = 1'b1;
            n_probe.hit_idx = MY_IDX;
            n_probe.hit_seq = r_last_seq;
        end
        if (!r_valid && !i_probe.free) begin
            n_probe.free     = 1'b1;
            n_probe.free_idx = MY_IDX;
        end
        if (r_valid && (r_last_seen < i_probe.min_t)) begin
            n_probe.min_t   = r_last_seen;
            n_probe.min_idx = MY_IDX;
        end
    end

    // Only the valid bits are reset; the probe payload follows every cycle and the entry fields load on a write.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_probe.valid <= 1'b0;
            r_valid       <= 1'b0;
        end else begin
            r_probe.valid <= i_probe.valid;
            if (w_sel && i_wr.open) begin
                r_valid <= 1'b1;
            end
        end
        r_probe.op       <= n_probe.op;
        r_probe.sid      <= n_probe.sid;
        r_probe.nsid     <= n_probe.nsid;
        r_probe.addr     <= n_probe.addr;
        r_probe.port     <= n_probe.port;
        r_probe.seq      <= n_probe.seq;
        r_probe.now      <= n_probe.now;
        r_probe.hit      <= n_probe.hit;
        r_probe.hit_idx  <= n_probe.hit_idx;
        r_probe.hit_seq  <= n_probe.hit_seq;
        r_probe.free     <= n_probe.free;
        r_probe.free_idx <= n_probe.free_idx;
        r_probe.min_t    <= n_probe.min_t;
        r_probe.min_idx  <= n_probe.min_idx;
        if (w_sel) begin
            r_last_seen <= i_wr.now;
            if (i_wr.open) begin
                r_id <= i_wr.id;
            end
            if (i_wr.set_addr) begin
                r_addr <= i_wr.addr;
                r_port <= i_wr.port;
            end
            if (i_wr.set_seq) begin
                r_last_seq <= i_wr.seq;
            end
        end
    end

    assign o_probe = r_probe;

endmodule

### rtl/core/session_table_replay_filter_core.sv
// Session table with least-recently-seen eviction and a replay filter.
// Top level: input capture, cell chain, decision and output register.
// Depends on stf_pkg and stf_cell.

// Usage: the block keeps SESSIONS session entries, one per cell in a chain.
// Each accepted item launches a probe that walks the chain one cell per
// cycle, collecting the first valid entry with a matching id, the first free
// entry and the valid entry with the smallest last-seen time (lowest index on
// ties). When the probe leaves the last cell, the block decides the status,
// loads the result register and, for an open, a resume hit or an accepted
// packet, sends one write command back to the chosen cell. An item passes the
// injection register, every cell, the finished-probe register and the result
// register in turn. A new item is accepted the cycle after the previous result
// was loaded, even while that result still waits to be taken. Only one
// item is in the chain at a time. Opening a session stores the new id with
// sequence zero; a data packet is dropped as a replay when its sequence is not
// newer than a nonzero stored one. The slot field reports the entry index
// modulo eight. Entry contents other than the valid bits are not reset.
module session_table_replay_filter_core #(
    parameter int SESSIONS = stf_pkg::SESSIONS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // hdr_id[63:0], new_id[127:64], peer_addr[159:128],
    // peer_port[175:160], seq[207:176], now_ms[239:208]
    input  logic [239:0] s_axis_tdata,
    // operation[1:0]
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // slot[2:0], id_out[66:3], evicted[67], zero fill[71:68]
    output logic [71:0]  m_axis_tdata,
    // status[2:0]
    output logic [2:0]   m_axis_tuser
);
    import stf_pkg::*;

    t_probe  w_probe [0:SESSIONS];
    t_probe  r_inj;
    t_probe  r_fin;
    t_wr_cmd r_wr;
    t_wr_cmd n_wr;

    logic        r_busy;
    logic        w_accept;
    logic        w_decide;

    logic        r_out_valid;
    logic [2:0]  r_out_status;
    logic [2:0]  r_out_slot;
    logic [63:0] r_out_id;
    logic        r_out_evicted;

    logic [2:0]       n_status;
    logic [IDX_W-1:0] n_idx;
    logic [63:0]      n_id_out;
    logic             n_evicted;

    assign s_axis_tready = !r_busy;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    // The finished probe waits in r_fin until the result register is free.
    assign w_decide      = r_fin.valid && (!r_out_valid || m_axis_tready);

    // The injection register feeds the first cell.
    assign w_probe[0] = r_inj;

    for (genvar k = 0; k < SESSIONS; k++) begin : g_cell
        stf_cell #(
            .IDX (k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_probe (w_probe[k]),
            .i_wr    (r_wr),
            .o_probe (w_probe[k+1])
        );
    end

    // A fresh probe starts with nothing found and the search minimum at its top.
    // Only the valid bits and the busy flag are reset; the payload fields load when their register takes a new probe.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_inj.valid <= 1'b0;
            r_fin.valid <= 1'b0;
        end else begin
            r_inj.valid <= w_accept;
            if (w_accept) begin
                r_busy <= 1'b1;
            end else if (w_decide) begin
                r_busy <= 1'b0;
            end
            if (w_probe[SESSIONS].valid) begin
                r_fin.valid <= 1'b1;
            end else if (w_decide) begin
                r_fin.valid <= 1'b0;
            end
        end
        if (w_accept) begin
            r_inj.op       <= s_axis_tuser;
            r_inj.sid      <= s_axis_tdata[63:0];
            r_inj.nsid     <= s_axis_tdata[127:64];
            r_inj.addr     <= s_axis_tdata[159:128];
            r_inj.port     <= s_axis_tdata[175:160];
            r_inj.seq      <= s_axis_tdata[207:176];
            r_inj.now      <= s_axis_tdata[239:208];
            r_inj.hit      <= 1'b0;
            r_inj.hit_idx  <= '0;
            r_inj.hit_seq  <= '0;
            r_inj.free     <= 1'b0;
            r_inj.free_idx <= '0;
            r_inj.min_t    <= '1;
            r_inj.min_idx  <= '0;
        end
        if (w_probe[SESSIONS].valid) begin
            r_fin.op       <= w_probe[SESSIONS].op;
            r_fin.sid      <= w_probe[SESSIONS].sid;
            r_fin.nsid     <= w_probe[SESSIONS].nsid;
            r_fin.addr     <= w_probe[SESSIONS].addr;
            r_fin.port     <= w_probe[SESSIONS].port;
            r_fin.seq      <= w_probe[SESSIONS].seq;
            r_fin.now      <= w_probe[SESSIONS].now;
            r_fin.hit      <= w_probe[SESSIONS].hit;
            r_fin.hit_idx  <= w_probe[SESSIONS].hit_idx;
            r_fin.hit_seq  <= w_probe[SESSIONS].hit_seq;
            r_fin.free     <= w_probe[SESSIONS].free;
            r_fin.free_idx <= w_probe[SESSIONS].free_idx;
            r_fin.min_t    <= w_probe[SESSIONS].min_t;
            r_fin.min_idx  <= w_probe[SESSIONS].min_idx;
        end
    end

    // Decision on the finished probe. Operation three is treated as a data
    // packet check, like operation two.
    always_comb begin
        n_status  = ST_UNKNOWN;
        n_idx     = '0;
        n_id_out  = r_fin.sid;
        n_evicted = 1'b0;

        n_wr          = '0;
        n_wr.id       = r_fin.nsid;
        n_wr.addr     = r_fin.addr;
        n_wr.port     = r_fin.port;
        n_wr.seq      = r_fin.seq;
        n_wr.now      = r_fin.now;

        unique case (r_fin.op)
            OP_OPEN: begin
                n_status  = ST_OPENED;
                n_id_out  = r_fin.nsid;
                n_idx     = r_fin.free ? r_fin.free_idx : r_fin.min_idx;
                n_evicted = !r_fin.free;
                n_wr.valid    = 1'b1;
                n_wr.open     = 1'b1;
                n_wr.set_addr = 1'b1;
                n_wr.set_seq  = 1'b1;
                n_wr.seq      = '0;
            end
            OP_RESUME: begin
                if (r_fin.hit) begin
                    n_status      = ST_RESUMED;
                    n_idx         = r_fin.hit_idx;
                    n_wr.valid    = 1'b1;
                    n_wr.set_addr = 1'b1;
                end
            end
            default: begin
                if (r_fin.hit) begin
                    n_idx = r_fin.hit_idx;
                    if ((r_fin.hit_seq != '0) && (r_fin.seq <= r_fin.hit_seq)) begin
                        n_status = ST_REPLAY;
                    end else begin
                        n_status     = ST_ACCEPTED;
                        n_wr.valid   = 1'b1;
                        n_wr.set_seq = 1'b1;
                    end
                end
            end
        endcase
        n_wr.idx   = n_idx;
        n_wr.valid = n_wr.valid && w_decide;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr.valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_wr.valid <= n_wr.valid;
            if (w_decide) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
        r_wr.idx      <= n_wr.idx;
        r_wr.open     <= n_wr.open;
        r_wr.set_addr <= n_wr.set_addr;
        r_wr.set_seq  <= n_wr.set_seq;
        r_wr.id       <= n_wr.id;
        r_wr.addr     <= n_wr.addr;
        r_wr.port     <= n_wr.port;
        r_wr.seq      <= n_wr.seq;
        r_wr.now      <= n_wr.now;
        if (w_decide) begin
            r_out_status  <= n_status;
            r_out_slot    <= n_idx[2:0];
            r_out_id      <= n_id_out;
            r_out_evicted <= n_evicted;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tdata  = {4'b0000, r_out_evicted, r_out_id, r_out_slot};

`ifndef SYNTHESIS
    a_wr_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wr.valid |-> (int'(r_wr.idx) < SESSIONS))
        else $error("table write addresses a cell beyond the table");

    a_result_from_probe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(r_fin.valid))
        else $error("result appeared without a finished probe");

    a_evict_only_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[67]) |-> (m_axis_tuser == ST_OPENED))
        else $error("eviction reported on a non-open item");

    a_single_probe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_probe[SESSIONS].valid |-> (r_busy && !r_fin.valid))
        else $error("probe left the chain while another was pending");
`endif

endmodule
